// File: hdl/ttsg_pkg.sv
package ttsg_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_FAIL   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_TOUCHED = 3'b010,
    MODE_WAITING = 3'b100
  } mode_t;

  localparam logic [1:0] CFG_REPEAT = 2'd0;
  localparam logic [1:0] CFG_LONG   = 2'd1;
  localparam logic [1:0] CFG_SLIDE  = 2'd2;

  localparam logic [15:0] RESET_REPEAT = 16'd200;
  localparam logic [15:0] RESET_LONG   = 16'd1000;
  localparam logic [15:0] RESET_SLIDE  = 16'd80;

  localparam logic [3:0] NO_CAND = 4'hF;

  typedef struct packed {
    logic [15:0] repeat_ms;
    logic [15:0] long_ms;
    logic [15:0] slide_ms;
  } cfg_t;

  typedef struct packed {
    logic       key_valid;
    logic [2:0] key_index;
    logic       slide_up;
    logic       slide_down;
  } res_t;

endpackage

// File: hdl/touch_tap_slider_gesture_fsm_top.sv
// channel | ports                                       | accepted when
// in      | in_valid in_stall in_command in_touch_status | in_valid && !in_stall
// out     | out_valid out_stall out_key_valid            | out_valid && !out_stall
//         | out_key_index out_slide_up out_slide_down    |
// cfg     | cfg_we cfg_index cfg_data                    | cfg_we
//
// One item per cycle while in_stall is low; each result is registered.
// The gesture state updates in the accept cycle; a two-entry output queue
// decouples the result side.
// in_stall rises only when both queue entries are held by a stalled output.
// rst_n is synchronous; all but the queue data registers have reset values.
module touch_tap_slider_gesture_fsm_top #(
  parameter int ELECTRODES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_touch_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_key_valid,
  output logic [2:0]  out_key_index,
  output logic        out_slide_up,
  output logic        out_slide_down,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ttsg_pkg::cfg_t cfg_r, cfg_nxt;
  ttsg_pkg::res_t res, out_res;
  logic           res_valid;
  logic           q_full;
  logic           item_acc;

  assign in_stall = q_full;
  assign item_acc = in_valid && !q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ttsg_pkg::CFG_REPEAT: cfg_nxt.repeat_ms = cfg_data;
        ttsg_pkg::CFG_LONG:   cfg_nxt.long_ms   = cfg_data;
        ttsg_pkg::CFG_SLIDE:  cfg_nxt.slide_ms  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_ms <= ttsg_pkg::RESET_REPEAT;
      cfg_r.long_ms   <= ttsg_pkg::RESET_LONG;
      cfg_r.slide_ms  <= ttsg_pkg::RESET_SLIDE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ttsg_core #(
    .ELECTRODES(ELECTRODES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (item_acc),
    .cmd      (in_command),
    .status   (in_touch_status),
    .cfg      (cfg_r),
    .res_valid(res_valid),
    .res      (res)
  );

  ttsg_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .full     (q_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign out_key_valid  = out_res.key_valid;
  assign out_key_index  = out_res.key_index;
  assign out_slide_up   = out_res.slide_up;
  assign out_slide_down = out_res.slide_down;

endmodule

// File: hdl/ttsg_core.sv
module ttsg_core #(
  parameter int ELECTRODES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_acc,
  input  logic [1:0]         cmd,
  input  logic [15:0]        status,
  input  ttsg_pkg::cfg_t     cfg,
  output logic               res_valid,
  output ttsg_pkg::res_t     res
);

  localparam logic [3:0] NUM_E = 4'(ELECTRODES);

  ttsg_pkg::mode_t mode_r, mode_nxt;
  logic [3:0]  cand_r, cand_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic        slid_r, slid_nxt;
  logic        rep_r, rep_nxt;
  logic [15:0] now_r, now_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [15:0] lrep_r, lrep_nxt;
  logic [15:0] lslide_r, lslide_nxt;
  logic [15:0] lkey_r, lkey_nxt;

  logic [15:0] since_slide, since_key, since_hold, since_rep;
  logic [ELECTRODES-1:0] move_mask, idle_mask;
  logic [3:0] move_sel, idle_sel;

  assign since_slide = now_r - lslide_r;
  assign since_key   = now_r - lkey_r;
  assign since_hold  = now_r - hold_r;
  assign since_rep   = now_r - lrep_r;

  always_comb begin
    move_sel = 4'd0;
    idle_sel = 4'd0;
    for (int i = 0; i < ELECTRODES; i++) begin
      move_mask[i] = status[i] && (4'(i) != cand_r);
      idle_mask[i] = status[i];
    end
    for (int i = ELECTRODES - 1; i >= 0; i--) begin
      if (move_mask[i]) move_sel = 4'(i);
      if (idle_mask[i]) idle_sel = 4'(i);
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    cand_nxt   = cand_r;
    prev_nxt   = prev_r;
    slid_nxt   = slid_r;
    rep_nxt    = rep_r;
    now_nxt    = now_r;
    hold_nxt   = hold_r;
    lrep_nxt   = lrep_r;
    lslide_nxt = lslide_r;
    lkey_nxt   = lkey_r;
    res        = '0;
    res_valid  = 1'b0;
    if (item_acc) begin
      unique case (ttsg_pkg::cmd_t'(cmd))
        ttsg_pkg::CMD_TICK: begin
          now_nxt = now_r + 16'd1;
        end
        ttsg_pkg::CMD_FAIL: begin
          res_valid = 1'b1;
        end
        ttsg_pkg::CMD_RSVD: begin
        end
        ttsg_pkg::CMD_SAMPLE: begin
          res_valid = 1'b1;
          prev_nxt  = status;
          unique case (mode_r)
            ttsg_pkg::MODE_TOUCHED: begin
              if (|move_mask) begin
                if (since_slide >= cfg.slide_ms && since_key >= cfg.slide_ms) begin
                  rep_nxt        = 1'b0;
                  res.slide_up   = cand_r > move_sel;
                  res.slide_down = !(cand_r > move_sel);
                  lslide_nxt     = now_r;
                end
                cand_nxt = move_sel;
                hold_nxt = now_r;
                slid_nxt = 1'b1;
              end else if (cand_r < NUM_E) begin
                if (prev_r[cand_r] && !status[cand_r]) begin
                  rep_nxt  = 1'b0;
                  mode_nxt = ttsg_pkg::MODE_WAITING;
                end else if (status[cand_r] && since_hold >= cfg.long_ms) begin
                  if (!rep_r || since_rep >= cfg.repeat_ms) begin
                    rep_nxt       = 1'b1;
                    lrep_nxt      = now_r;
                    lkey_nxt      = now_r;
                    res.key_valid = 1'b1;
                    res.key_index = cand_r[2:0];
                  end
                end
              end
            end
            ttsg_pkg::MODE_WAITING: begin
              if (status == 16'd0) begin
                if (!slid_r) begin
                  if (cand_r < NUM_E) begin
                    res.key_valid = 1'b1;
                    res.key_index = cand_r[2:0];
                  end
                  lkey_nxt = now_r;
                end
                cand_nxt = ttsg_pkg::NO_CAND;
                mode_nxt = ttsg_pkg::MODE_IDLE;
                slid_nxt = 1'b0;
              end
            end
            ttsg_pkg::MODE_IDLE: begin
              if (prev_r == 16'd0 && |idle_mask) begin
                cand_nxt = idle_sel;
                mode_nxt = ttsg_pkg::MODE_TOUCHED;
                slid_nxt = 1'b0;
                hold_nxt = now_r;
                rep_nxt  = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ttsg_pkg::MODE_IDLE;
      cand_r   <= ttsg_pkg::NO_CAND;
      prev_r   <= 16'd0;
      slid_r   <= 1'b0;
      rep_r    <= 1'b0;
      now_r    <= 16'd0;
      hold_r   <= 16'd0;
      lrep_r   <= 16'd0;
      lslide_r <= 16'd0;
      lkey_r   <= 16'd0;
    end else begin
      mode_r   <= mode_nxt;
      cand_r   <= cand_nxt;
      prev_r   <= prev_nxt;
      slid_r   <= slid_nxt;
      rep_r    <= rep_nxt;
      now_r    <= now_nxt;
      hold_r   <= hold_nxt;
      lrep_r   <= lrep_nxt;
      lslide_r <= lslide_nxt;
      lkey_r   <= lkey_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cand_held: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != ttsg_pkg::MODE_IDLE) |-> (cand_r < NUM_E))
    else $error("active mode without a valid candidate");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == ttsg_pkg::MODE_IDLE) |-> !slid_r)
    else $error("slid flag left set in idle");

  a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (item_acc && cmd == ttsg_pkg::CMD_TICK) |-> !res_valid)
    else $error("tick produced a result");
`endif

endmodule

// File: hdl/ttsg_outq.sv
module ttsg_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttsg_pkg::res_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output ttsg_pkg::res_t out_data
);

  logic           main_v_r, main_v_nxt;
  logic           skid_v_r, skid_v_nxt;
  ttsg_pkg::res_t main_r, main_nxt;
  ttsg_pkg::res_t skid_r, skid_nxt;
  logic           take;

  assign take      = !main_v_r || !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (take) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_nxt   = skid_r;
        skid_v_nxt = push;
        skid_nxt   = push_data;
      end else begin
        main_v_nxt = push;
        main_nxt   = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

`ifndef ASSERT_OFF
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry without head entry");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_v_r)
    else $error("item pushed into full queue");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
`endif

endmodule

// File: bench/tb_touch_tap_slider_gesture_fsm_top.sv
`timescale 1ns / 100ps

module tb_touch_tap_slider_gesture_fsm_top;

  localparam int N_ELEC = 8;
  localparam int WATCHDOG = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = ttsg_pkg::CMD_TICK;
  logic [15:0] in_touch_status = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_key_valid;
  logic [2:0]  out_key_index;
  logic        out_slide_up;
  logic        out_slide_down;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = ttsg_pkg::CFG_REPEAT;
  logic [15:0] cfg_data = 16'h0000;

  touch_tap_slider_gesture_fsm_top #(.ELECTRODES(N_ELEC)) dut (.*);

  // gesture tracker state
  ttsg_pkg::cfg_t  gcfg;
  ttsg_pkg::mode_t g_mode;
  logic [3:0]  g_cand;
  logic [15:0] g_prev;
  bit          g_slid;
  bit          g_repeating;
  logic [15:0] now_ms;
  logic [15:0] hold_start;
  logic [15:0] last_repeat;
  logic [15:0] last_slide;
  logic [15:0] last_key;

  ttsg_pkg::res_t expected_events[$];
  int   mismatches = 0;
  int   items_sent = 0;
  int   idle_cycles = 0;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  int   hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic gesture_reset();
    gcfg.repeat_ms = ttsg_pkg::RESET_REPEAT;
    gcfg.long_ms   = ttsg_pkg::RESET_LONG;
    gcfg.slide_ms  = ttsg_pkg::RESET_SLIDE;
    g_mode      = ttsg_pkg::MODE_IDLE;
    g_cand      = ttsg_pkg::NO_CAND;
    g_prev      = 16'h0000;
    g_slid      = 1'b0;
    g_repeating = 1'b0;
    now_ms      = 16'h0000;
    hold_start  = 16'h0000;
    last_repeat = 16'h0000;
    last_slide  = 16'h0000;
    last_key    = 16'h0000;
  endtask

  // Returns 1 when the item yields a result.
  function automatic bit classify_item(input ttsg_pkg::cmd_t c, input logic [15:0] cur,
                                       output ttsg_pkg::res_t r);
    logic [15:0] prev;
    logic [15:0] dt_a;
    logic [15:0] dt_b;
    bit moved;
    bit found;
    r = '0;
    prev = g_prev;
    moved = 1'b0;
    found = 1'b0;
    case (c)
      ttsg_pkg::CMD_TICK: begin
        now_ms = now_ms + 16'd1;
        return 1'b0;
      end
      ttsg_pkg::CMD_RSVD: return 1'b0;
      ttsg_pkg::CMD_FAIL: return 1'b1;
      default: ;
    endcase
    g_prev = cur;
    if (g_mode == ttsg_pkg::MODE_TOUCHED) begin
      for (int i = 0; i < N_ELEC; i++) begin
        if (!moved && i != g_cand && cur[i]) begin
          dt_a = now_ms - last_slide;
          dt_b = now_ms - last_key;
          if (dt_a >= gcfg.slide_ms && dt_b >= gcfg.slide_ms) begin
            g_repeating = 1'b0;
            if (g_cand > i) begin
              r.slide_up = 1'b1;
            end else begin
              r.slide_down = 1'b1;
            end
            last_slide = now_ms;
          end
          g_cand = i[3:0];
          hold_start = now_ms;
          g_slid = 1'b1;
          moved = 1'b1;
        end
      end
      if (!moved && g_cand < N_ELEC) begin
        dt_a = now_ms - hold_start;
        dt_b = now_ms - last_repeat;
        if (prev[g_cand] && !cur[g_cand]) begin
          g_repeating = 1'b0;
          g_mode = ttsg_pkg::MODE_WAITING;
        end else if (cur[g_cand] && dt_a >= gcfg.long_ms) begin
          if (!g_repeating || dt_b >= gcfg.repeat_ms) begin
            g_repeating = 1'b1;
            last_repeat = now_ms;
            last_key = now_ms;
            r.key_valid = 1'b1;
            r.key_index = g_cand[2:0];
          end
        end
      end
    end else if (g_mode == ttsg_pkg::MODE_WAITING) begin
      if (cur == 16'h0000) begin
        if (!g_slid) begin
          if (g_cand < N_ELEC) begin
            r.key_valid = 1'b1;
            r.key_index = g_cand[2:0];
          end
          last_key = now_ms;
        end
        g_cand = ttsg_pkg::NO_CAND;
        g_mode = ttsg_pkg::MODE_IDLE;
        g_slid = 1'b0;
      end
    end else if (prev == 16'h0000) begin
      for (int i = 0; i < N_ELEC; i++) begin
        if (!found && cur[i]) begin
          g_cand = i[3:0];
          g_mode = ttsg_pkg::MODE_TOUCHED;
          g_slid = 1'b0;
          hold_start = now_ms;
          g_repeating = 1'b0;
          found = 1'b1;
        end
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    ttsg_pkg::res_t want;
    bit busy;
    busy = 1'b0;
    if (!rst_n) begin
      gesture_reset();
      expected_events.delete();
    end else begin
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_events.pop_front();
          if (out_key_valid !== want.key_valid)
            report_mismatch("key_valid", int'(out_key_valid), int'(want.key_valid));
          if (out_key_index !== want.key_index)
            report_mismatch("key_index", int'(out_key_index), int'(want.key_index));
          if (out_slide_up !== want.slide_up)
            report_mismatch("slide_up", int'(out_slide_up), int'(want.slide_up));
          if (out_slide_down !== want.slide_down)
            report_mismatch("slide_down", int'(out_slide_down), int'(want.slide_down));
        end
      end
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        if (classify_item(ttsg_pkg::cmd_t'(in_command), in_touch_status, want))
          expected_events.push_back(want);
      end
      if (cfg_we) begin
        busy = 1'b1;
        case (cfg_index)
          ttsg_pkg::CFG_REPEAT: gcfg.repeat_ms = cfg_data;
          ttsg_pkg::CFG_LONG:   gcfg.long_ms   = cfg_data;
          ttsg_pkg::CFG_SLIDE:  gcfg.slide_ms  = cfg_data;
          default: ;
        endcase
      end
    end
    idle_cycles = busy ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall, or a forced hold-off while hold_left runs down
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  task automatic send_item(input ttsg_pkg::cmd_t c, input logic [15:0] st);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_touch_status <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c != ttsg_pkg::CMD_RSVD) items_sent++;
  endtask

  task automatic touch(input logic [15:0] st);
    send_item(ttsg_pkg::CMD_SAMPLE, st);
  endtask

  task automatic tick_n(input int n);
    repeat (n) send_item(ttsg_pkg::CMD_TICK, 16'h0000);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] rep, input logic [15:0] lng,
                            input logic [15:0] sld);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ttsg_pkg::CFG_REPEAT;
    cfg_data <= rep;
    @(negedge clk);
    cfg_index <= ttsg_pkg::CFG_LONG;
    cfg_data <= lng;
    @(negedge clk);
    cfg_index <= ttsg_pkg::CFG_SLIDE;
    cfg_data <= sld;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] junk_bits();
    logic [15:0] j;
    j = rand16();
    return ($urandom_range(0, 3) == 0) ? (j & 16'hFF00) : 16'h0000;
  endfunction

  task automatic noise_burst();
    repeat ($urandom_range(1, 4))
      send_item(ttsg_pkg::cmd_t'($urandom_range(0, 3)), rand16());
  endtask

  // press, optional holds/slides/ticks/failed reads, release
  task automatic rand_gesture();
    int e;
    logic [15:0] held;
    touch(16'h0000);
    tick_n($urandom_range(0, 3));
    e = int'($urandom_range(0, N_ELEC - 1));
    held = (16'h0001 << e) | junk_bits();
    touch(held);
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 5))
        0: tick_n($urandom_range(1, 6));
        1: touch(held);
        2: begin
          e = int'((e + $urandom_range(1, N_ELEC - 1)) % N_ELEC);
          held = ($urandom_range(0, 1) ? held : 16'h0000) | (16'h0001 << e) | junk_bits();
          touch(held);
        end
        3: send_item(ttsg_pkg::CMD_FAIL, rand16());
        default: begin
          tick_n($urandom_range(4, 25));
          touch(held);
        end
      endcase
    end
    if ($urandom_range(0, 1)) touch(held & ~(16'h0001 << e));
    touch(16'h0000);
  endtask

  task automatic test_reset_values();
    touch(16'h0001);
    touch(16'h0000);
    touch(16'h0000);
    tick_n(40);
    touch(16'h0004);
    touch(16'h0006);       // slide inside the 80 ms window: dropped
    tick_n(45);
    touch(16'h0003);       // slide allowed now
    touch(16'h0000);
    touch(16'h0000);       // no tap after a slide
    touch(16'h0020);
    tick_n(999);
    touch(16'h0020);
    tick_n(1);
    touch(16'h0020);       // first long press key
    tick_n(199);
    touch(16'h0020);
    tick_n(1);
    touch(16'h0020);       // repeat
    touch(16'h0000);
    touch(16'h0000);
    wait_drain();
  endtask

  task automatic test_directed();
    set_config(16'd3, 16'd5, 16'd2);
    touch(16'h0080);
    touch(16'h0000);
    touch(16'h0000);
    touch(16'hFF00);       // only electrodes beyond range
    touch(16'hFF80);
    touch(16'h0000);
    touch(16'hFFFF);
    touch(16'hFFFF);
    send_item(ttsg_pkg::CMD_FAIL, 16'hFFFF);
    send_item(ttsg_pkg::CMD_RSVD, 16'hA5A5);
    touch(16'h0000);
    touch(16'h0000);
    touch(16'h0002);
    touch(16'h0100);       // release, high bit keeps waiting
    touch(16'h0100);
    touch(16'h0000);
    tick_n(6);
    touch(16'h0010);
    tick_n(5);
    touch(16'h0010);
    touch(16'h0010);
    tick_n(3);
    touch(16'h0010);
    touch(16'h0000);
    touch(16'h0000);
    wait_drain();
  endtask

  task automatic test_interval_extremes();
    set_config(16'd0, 16'd0, 16'd0);
    repeat (12) rand_gesture();
    wait_drain();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (12) rand_gesture();
    wait_drain();
  endtask

  task automatic test_tick_wrap();
    logic [15:0] gap;
    set_config(16'd2, 16'd6, 16'd4);
    touch(16'h0000);
    touch(16'h0000);
    gap = 16'd65533 - now_ms;
    tick_n(int'(gap));
    touch(16'h0008);
    tick_n(4);
    touch(16'h0008);
    tick_n(2);
    touch(16'h0008);       // long press across the wrap
    touch(16'h000C);
    tick_n(4);
    touch(16'h0008);
    touch(16'h0000);
    touch(16'h0000);
    wait_drain();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_left = 250;
    repeat (10) begin
      touch(16'h0004);
      send_item(ttsg_pkg::CMD_FAIL, rand16());
    end
    touch(16'h0000);
    wait_drain();
  endtask

  task automatic test_random(input int src_pct, input int snk_pct, input int n_items,
                             input int rmax);
    int stop_at;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    set_config(16'($urandom_range(0, rmax)), 16'($urandom_range(0, rmax)),
               16'($urandom_range(0, rmax)));
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        noise_burst();
      end else begin
        rand_gesture();
      end
    end
    wait_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed();
    test_interval_extremes();
    test_tick_wrap();
    test_backpressure();
    test_random(0, 0, 140, 20);
    test_random(78, 0, 140, 40);
    test_random(0, 78, 140, 12);
    test_random(34, 34, 140, 30);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
